@@ sv/qcao_pkg.sv @@
`timescale 1ns / 1ps

package qcao_pkg;

  // Corners per quadrilateral and the bits needed to rank them
  localparam int NUM_CORNERS = 4;
  localparam int RANK_W      = 2;

  // Angle classes, in ascending angle order
  typedef enum logic [1:0] {
    CLS_BELOW = 2'd0,  // offset y < 0, angle in (-pi, 0)
    CLS_ZERO  = 2'd1,  // offset y == 0, offset x >= 0, angle 0
    CLS_ABOVE = 2'd2,  // offset y > 0, angle in (0, pi)
    CLS_LEFT  = 2'd3   // offset y == 0, offset x < 0, angle pi
  } angle_cls_t;

  // Pipeline advance and occupancy shared by the lanes and the merge
  typedef struct packed {
    logic en_b;
    logic en_c;
    logic en_d;
    logic en_e;
    logic v_d;
  } pipe_ctl_t;

endpackage

@@ sv/qcao_corner_lane.sv @@
`timescale 1ns / 1ps

module qcao_corner_lane #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  qcao_pkg::pipe_ctl_t          ctl,
  input  logic [COORD_BITS-1:0]        x,
  input  logic [COORD_BITS-1:0]        y,
  input  logic signed [COORD_BITS+2:0] ox,
  input  logic signed [COORD_BITS+2:0] oy,
  output qcao_pkg::angle_cls_t         cls,
  output logic [COORD_BITS-1:0]        x_c,
  output logic [COORD_BITS-1:0]        y_c,
  output logic [2*COORD_BITS:0]        dist_c
);

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 1;

  qcao_pkg::angle_cls_t    cls_next;
  logic [COORD_BITS-1:0]   x_b;
  logic [COORD_BITS-1:0]   y_b;
  logic [SQ_W-1:0]         xx;
  logic [SQ_W-1:0]         yy;

  // Classify the offset into its half-plane
  always_comb begin
    if (oy < 0) begin
      cls_next = qcao_pkg::CLS_BELOW;
    end else if (oy == 0 && ox >= 0) begin
      cls_next = qcao_pkg::CLS_ZERO;
    end else if (oy > 0) begin
      cls_next = qcao_pkg::CLS_ABOVE;
    end else begin
      cls_next = qcao_pkg::CLS_LEFT;
    end
  end

  // Stage B: square the coordinates, hold the class
  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      cls <= cls_next;
      x_b <= x;
      y_b <= y;
      xx  <= x * x;
      yy  <= y * y;
    end
  end

  // Stage C: squared distance from the origin
  always_ff @(posedge clk) begin
    if (ctl.en_c) begin
      x_c    <= x_b;
      y_c    <= y_b;
      dist_c <= DIST_W'(xx) + DIST_W'(yy);
    end
  end

endmodule

@@ sv/qcao_pair_lane.sv @@
`timescale 1ns / 1ps

module qcao_pair_lane #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  qcao_pkg::pipe_ctl_t          ctl,
  input  logic signed [COORD_BITS+2:0] a_ox,
  input  logic signed [COORD_BITS+2:0] a_oy,
  input  logic signed [COORD_BITS+2:0] b_ox,
  input  logic signed [COORD_BITS+2:0] b_oy,
  input  qcao_pkg::angle_cls_t         cls_a,
  input  qcao_pkg::angle_cls_t         cls_b,
  output logic                         a_before_b,
  output logic                         b_before_a
);

  localparam int OFS_W  = COORD_BITS + 3;
  localparam int PROD_W = 2 * OFS_W;

  logic signed [PROD_W-1:0] pab;
  logic signed [PROD_W-1:0] pba;
  logic signed [PROD_W:0]   cross_term;
  logic                     cross_pos;
  logic                     cross_neg;
  logic                     same_cls;
  logic                     open_half;
  logic                     ab_next;
  logic                     ba_next;

  // Stage B: the two products of the cross term
  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      pab <= a_ox * b_oy;
      pba <= a_oy * b_ox;
    end
  end

  // Compare classes first, then the cross product sign within a half-plane
  always_comb begin
    cross_term = (PROD_W + 1)'(pab) - (PROD_W + 1)'(pba);
    cross_neg  = cross_term[PROD_W];
    cross_pos  = !cross_term[PROD_W] && (cross_term != '0);
    same_cls   = (cls_a == cls_b);
    open_half  = (cls_a == qcao_pkg::CLS_BELOW) || (cls_a == qcao_pkg::CLS_ABOVE);
    ab_next    = (cls_a < cls_b) || (same_cls && open_half && cross_pos);
    ba_next    = (cls_b < cls_a) || (same_cls && open_half && cross_neg);
  end

  // Stage C: ordering bits for the pair
  always_ff @(posedge clk) begin
    if (ctl.en_c) begin
      a_before_b <= ab_next;
      b_before_a <= ba_next;
    end
  end

endmodule

@@ sv/qcao_merge.sv @@
`timescale 1ns / 1ps

module qcao_merge #(
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  qcao_pkg::pipe_ctl_t    ctl,
  input  logic [COORD_BITS-1:0]  x_c    [qcao_pkg::NUM_CORNERS],
  input  logic [COORD_BITS-1:0]  y_c    [qcao_pkg::NUM_CORNERS],
  input  logic [2*COORD_BITS:0]  dist_c [qcao_pkg::NUM_CORNERS],
  // before_c[a][b]: corner a sorts ahead of corner b
  input  logic [qcao_pkg::NUM_CORNERS-1:0][qcao_pkg::NUM_CORNERS-1:0] before_c,
  output logic [COORD_BITS-1:0]  q_x    [qcao_pkg::NUM_CORNERS],
  output logic [COORD_BITS-1:0]  q_y    [qcao_pkg::NUM_CORNERS]
);

  localparam int NC     = qcao_pkg::NUM_CORNERS;
  localparam int RW     = qcao_pkg::RANK_W;
  localparam int DIST_W = 2 * COORD_BITS + 1;

  logic [RW-1:0]          rank_next [NC];
  logic [RW-1:0]          rank_d    [NC];
  logic [DIST_W-1:0]      dist_d    [NC];
  logic [COORD_BITS-1:0]  x_d       [NC];
  logic [COORD_BITS-1:0]  y_d       [NC];
  logic [NC-1:0]          win;
  logic [RW-1:0]          first_rank;
  logic [NC-1:0][NC-1:0]  hit;
  logic [COORD_BITS-1:0]  q_x_next  [NC];
  logic [COORD_BITS-1:0]  q_y_next  [NC];

  // Stable sort position: earlier corners of equal angle stay ahead
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      rank_next[i] = '0;
      for (int j = 0; j < NC; j++) begin
        if (j < i) begin
          rank_next[i] = rank_next[i] + RW'(!before_c[i][j]);
        end else if (j > i) begin
          rank_next[i] = rank_next[i] + RW'(before_c[j][i]);
        end
      end
    end
  end

  // Stage D: ranks, distances and coordinates
  always_ff @(posedge clk) begin
    if (ctl.en_d) begin
      for (int i = 0; i < NC; i++) begin
        rank_d[i] <= rank_next[i];
        dist_d[i] <= dist_c[i];
        x_d[i]    <= x_c[i];
        y_d[i]    <= y_c[i];
      end
    end
  end

  // Pick the nearest corner, ties going to the earlier sorted position
  always_comb begin
    win        = '1;
    first_rank = '0;
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        if (j != i) begin
          if (!((dist_d[i] < dist_d[j]) ||
                ((dist_d[i] == dist_d[j]) && (rank_d[i] < rank_d[j])))) begin
            win[i] = 1'b0;
          end
        end
      end
    end
    for (int i = 0; i < NC; i++) begin
      if (win[i]) begin
        first_rank = first_rank | rank_d[i];
      end
    end
  end

  // Rotate the sorted list so the nearest corner leads
  always_comb begin
    for (int p = 0; p < NC; p++) begin
      q_x_next[p] = '0;
      q_y_next[p] = '0;
      for (int i = 0; i < NC; i++) begin
        hit[p][i] = (rank_d[i] == RW'(RW'(p) + first_rank));
        if (hit[p][i]) begin
          q_x_next[p] = q_x_next[p] | x_d[i];
          q_y_next[p] = q_y_next[p] | y_d[i];
        end
      end
    end
  end

  // Stage E: output word
  always_ff @(posedge clk) begin
    if (ctl.en_e) begin
      for (int p = 0; p < NC; p++) begin
        q_x[p] <= q_x_next[p];
        q_y[p] <= q_y_next[p];
      end
    end
  end

  // Exactly one corner wins the distance compare
  a_one_winner: assert property (@(posedge clk) disable iff (rst)
    ctl.v_d |-> $onehot(win))
    else $error("nearest corner pick is not unique");

  // Ranks form a permutation, so every output slot gets exactly one corner
  a_rank_perm: assert property (@(posedge clk) disable iff (rst)
    ctl.v_d |-> ($onehot(hit[0]) && $onehot(hit[1]) &&
                 $onehot(hit[2]) && $onehot(hit[3])))
    else $error("sort ranks are not a permutation");

endmodule

@@ sv/quad_corner_angular_order_core.sv @@
`timescale 1ns / 1ps

// Quadrilateral corner ordering.
// Input stream (s_*): one word carries four corners p0..p3, each as an
// unsigned x and y of COORD_BITS bits. Output stream (m_*): one word carries
// the same four corners reordered q0..q3: counter-clockwise by angle around
// the centroid, rotated so that the corner nearest the origin comes first.
// Every input word produces exactly one output word; the block keeps no
// state between words.
// The word passes through the stage registers A, B, C, D and E in order, and
// m_tvalid rises when it reaches E. Throughput: one word per cycle while the
// receiver takes words; the five pipeline registers each advance when empty
// or when the register after them advances.
// Reset clears the pipeline valid bits; no word is pending afterwards.
// When the receiver stalls, the output word holds and the pipeline fills
// behind it; s_tready drops only when all five stages hold words.
module quad_corner_angular_order_core #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (lowest bits first)
  input  logic [((8*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y (lowest bits first)
  output logic [((8*COORD_BITS+7)/8)*8-1:0] m_tdata
);

  localparam int NC    = qcao_pkg::NUM_CORNERS;
  localparam int SUM_W = COORD_BITS + 2;
  localparam int OFS_W = COORD_BITS + 3;

  logic [COORD_BITS-1:0]   px     [NC];
  logic [COORD_BITS-1:0]   py     [NC];
  logic [SUM_W-1:0]        sum_x;
  logic [SUM_W-1:0]        sum_y;
  logic signed [OFS_W-1:0] ox_next [NC];
  logic signed [OFS_W-1:0] oy_next [NC];

  logic [COORD_BITS-1:0]   ax     [NC];
  logic [COORD_BITS-1:0]   ay     [NC];
  logic signed [OFS_W-1:0] aox    [NC];
  logic signed [OFS_W-1:0] aoy    [NC];

  qcao_pkg::angle_cls_t    cls    [NC];
  logic [COORD_BITS-1:0]   x_c    [NC];
  logic [COORD_BITS-1:0]   y_c    [NC];
  logic [2*COORD_BITS:0]   dist_c [NC];
  logic [NC-1:0][NC-1:0]   before_c;
  logic [COORD_BITS-1:0]   q_x    [NC];
  logic [COORD_BITS-1:0]   q_y    [NC];

  logic vld_a, vld_b, vld_c, vld_d, vld_e;
  logic en_a, en_b, en_c, en_d, en_e;
  qcao_pkg::pipe_ctl_t ctl;

  // Advance each stage when it is empty or the next one advances
  assign en_e     = !vld_e || m_tready;
  assign en_d     = !vld_d || en_e;
  assign en_c     = !vld_c || en_d;
  assign en_b     = !vld_b || en_c;
  assign en_a     = !vld_a || en_b;
  assign s_tready = en_a;
  assign m_tvalid = vld_e;

  assign ctl.en_b = en_b;
  assign ctl.en_c = en_c;
  assign ctl.en_d = en_d;
  assign ctl.en_e = en_e;
  assign ctl.v_d  = vld_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
      vld_e <= 1'b0;
    end else begin
      if (en_a) vld_a <= s_tvalid;
      if (en_b) vld_b <= vld_a;
      if (en_c) vld_c <= vld_b;
      if (en_d) vld_d <= vld_c;
      if (en_e) vld_e <= vld_d;
    end
  end

  // Unpack corners, form 4*p minus the coordinate sum
  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int i = 0; i < NC; i++) begin
      px[i] = s_tdata[(2*i)*COORD_BITS +: COORD_BITS];
      py[i] = s_tdata[(2*i+1)*COORD_BITS +: COORD_BITS];
      sum_x = sum_x + SUM_W'(px[i]);
      sum_y = sum_y + SUM_W'(py[i]);
    end
    for (int i = 0; i < NC; i++) begin
      ox_next[i] = {1'b0, px[i], 2'b00} - {1'b0, sum_x};
      oy_next[i] = {1'b0, py[i], 2'b00} - {1'b0, sum_y};
    end
  end

  // Stage A: coordinates and centroid offsets
  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int i = 0; i < NC; i++) begin
        ax[i]  <= px[i];
        ay[i]  <= py[i];
        aox[i] <= ox_next[i];
        aoy[i] <= oy_next[i];
      end
    end
  end

  // One lane per corner
  for (genvar i = 0; i < NC; i++) begin : g_corner
    qcao_corner_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .x      (ax[i]),
      .y      (ay[i]),
      .ox     (aox[i]),
      .oy     (aoy[i]),
      .cls    (cls[i]),
      .x_c    (x_c[i]),
      .y_c    (y_c[i]),
      .dist_c (dist_c[i])
    );
  end

  // One lane per pair of corners
  for (genvar a = 0; a < NC; a++) begin : g_row
    assign before_c[a][a] = 1'b0;
    for (genvar b = a + 1; b < NC; b++) begin : g_pair
      qcao_pair_lane #(
        .COORD_BITS (COORD_BITS)
      ) u_pair (
        .clk        (clk),
        .ctl        (ctl),
        .a_ox       (aox[a]),
        .a_oy       (aoy[a]),
        .b_ox       (aox[b]),
        .b_oy       (aoy[b]),
        .cls_a      (cls[a]),
        .cls_b      (cls[b]),
        .a_before_b (before_c[a][b]),
        .b_before_a (before_c[b][a])
      );
    end
  end

  qcao_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .x_c      (x_c),
    .y_c      (y_c),
    .dist_c   (dist_c),
    .before_c (before_c),
    .q_x      (q_x),
    .q_y      (q_y)
  );

  // Pack the output word
  always_comb begin
    m_tdata = '0;
    for (int p = 0; p < NC; p++) begin
      m_tdata[(2*p)*COORD_BITS +: COORD_BITS]   = q_x[p];
      m_tdata[(2*p+1)*COORD_BITS +: COORD_BITS] = q_y[p];
    end
  end

  // Input back-pressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output is free");

  // An accepted word enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld_a)
    else $error("accepted word lost at the first stage");

  // A full pipeline with a stalled output refuses input
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (vld_a && vld_b && vld_c && vld_d && vld_e && !m_tready) |-> !s_tready)
    else $error("input taken while pipeline is full and stalled");

endmodule

@@ test/quad_corner_order_checker.sv @@
`timescale 1ns / 1ps

// Watches both stream channels of the corner-ordering core. Every accepted
// input word is run through a local predictor and its ordered quad queued;
// every accepted output word is checked field by field against the oldest
// queued quad.
module quad_corner_order_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (lowest bits first)
  input  logic [((8*COORD_BITS+7)/8)*8-1:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  // q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y (lowest bits first)
  input  logic [((8*COORD_BITS+7)/8)*8-1:0] m_tdata,
  output int   fail_count,
  output int   pending_count
);

  localparam int CB = COORD_BITS;
  localparam int DW = ((8*COORD_BITS+7)/8)*8;

  // One corner with its offset from the centroid, scaled by four
  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    longint        ox;
    longint        oy;
  } quad_corner_t;

  logic [DW-1:0] ordered_quads[$];

  function automatic qcao_pkg::angle_cls_t corner_class(quad_corner_t c);
    if (c.oy < 0) return qcao_pkg::CLS_BELOW;
    if (c.oy == 0 && c.ox >= 0) return qcao_pkg::CLS_ZERO;
    if (c.oy > 0) return qcao_pkg::CLS_ABOVE;
    return qcao_pkg::CLS_LEFT;
  endfunction

  // True when a lies at a strictly smaller angle than b
  function automatic bit angle_precedes(quad_corner_t a, quad_corner_t b);
    qcao_pkg::angle_cls_t ca;
    qcao_pkg::angle_cls_t cb;
    ca = corner_class(a);
    cb = corner_class(b);
    if (ca != cb) return ca < cb;
    if (ca == qcao_pkg::CLS_ZERO || ca == qcao_pkg::CLS_LEFT) return 1'b0;
    return (a.ox * b.oy - a.oy * b.ox) > 0;
  endfunction

  // Sort the four corners by angle around the centroid, then rotate so the
  // first corner nearest the origin leads
  function automatic logic [DW-1:0] order_corners(logic [DW-1:0] quad);
    quad_corner_t       c[4];
    quad_corner_t       t;
    longint             sx;
    longint             sy;
    longint unsigned    best;
    longint unsigned    d;
    int                 i;
    int                 j;
    int                 first;
    logic [DW-1:0]      res;
    sx = 0;
    sy = 0;
    for (i = 0; i < 4; i++) begin
      c[i].x = quad[CB*(2*i) +: CB];
      c[i].y = quad[CB*(2*i+1) +: CB];
      sx += longint'(c[i].x);
      sy += longint'(c[i].y);
    end
    for (i = 0; i < 4; i++) begin
      c[i].ox = 4 * longint'(c[i].x) - sx;
      c[i].oy = 4 * longint'(c[i].y) - sy;
    end
    // stable insertion sort, equal angles keep input order
    for (i = 1; i < 4; i++) begin
      t = c[i];
      j = i - 1;
      while (j >= 0 && angle_precedes(t, c[j])) begin
        c[j+1] = c[j];
        j--;
      end
      c[j+1] = t;
    end
    first = 0;
    best = longint'(c[0].x) * longint'(c[0].x) + longint'(c[0].y) * longint'(c[0].y);
    for (i = 1; i < 4; i++) begin
      d = longint'(c[i].x) * longint'(c[i].x) + longint'(c[i].y) * longint'(c[i].y);
      if (d < best) begin
        best = d;
        first = i;
      end
    end
    res = '0;
    for (i = 0; i < 4; i++) begin
      res[CB*(2*i) +: CB]   = c[(i + first) & 3].x;
      res[CB*(2*i+1) +: CB] = c[(i + first) & 3].y;
    end
    return res;
  endfunction

  // Check the output word first, then queue the prediction for the input word
  always @(posedge clk) begin : watch
    logic [DW-1:0] want;
    int            bad;
    int            k;
    bad = 0;
    if (rst) begin
      ordered_quads.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (ordered_quads.size() == 0) begin
          $display("%0t ns: output word with none expected, expected nothing, got %h",
                   $time, m_tdata);
          bad = 1;
        end else begin
          want = ordered_quads.pop_front();
          for (k = 0; k < 8; k++) begin
            if (m_tdata[CB*k +: CB] !== want[CB*k +: CB]) begin
              $display("%0t ns: q%0d_%s expected %h, got %h", $time, k / 2,
                       (k % 2) ? "y" : "x", want[CB*k +: CB], m_tdata[CB*k +: CB]);
              bad++;
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        ordered_quads = {ordered_quads, order_corners(s_tdata)};
      fail_count    <= fail_count + bad;
      pending_count <= ordered_quads.size();
    end
  end

endmodule

@@ test/quad_corner_angular_order_core_test.sv @@
`timescale 1ns / 1ps

module quad_corner_angular_order_core_test;

  localparam int CB           = 16;
  localparam int DW           = ((8*CB+7)/8)*8;
  localparam int RANDOM_QUADS = 900;
  localparam int STALL_AT     = 300;
  localparam int STALL_CYCLES = 60;
  localparam int LIMIT_CYCLES = 400000;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [DW-1:0] s_tdata;
  logic          m_tvalid;
  logic          m_tready;
  logic [DW-1:0] m_tdata;
  int            fail_count;
  int            pending_count;
  int            cycle_count;
  int            quads_sent;
  bit            long_hold_done;

  quad_corner_angular_order_core #(
    .COORD_BITS(CB)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  quad_corner_order_checker #(
    .COORD_BITS(CB)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    cycle_count    = 0;
    quads_sent     = 0;
    long_hold_done = 1'b0;
  end

  always #2 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mostly short idle gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [DW-1:0] pack_quad(
    logic [CB-1:0] x0, logic [CB-1:0] y0, logic [CB-1:0] x1, logic [CB-1:0] y1,
    logic [CB-1:0] x2, logic [CB-1:0] y2, logic [CB-1:0] x3, logic [CB-1:0] y3);
    logic [DW-1:0] w;
    w = '0;
    w[8*CB-1:0] = {y3, x3, y2, x2, y1, x1, y0, x0};
    return w;
  endfunction

  // Random quad: half are jittered rectangles in shuffled corner order, the
  // rest fully random, tiny coordinates full of ties, or extreme values
  function automatic logic [DW-1:0] random_quad();
    logic [CB-1:0] px[4];
    logic [CB-1:0] py[4];
    logic [CB-1:0] tx;
    logic [CB-1:0] ty;
    int            r;
    int            half;
    int            jit;
    int            mx;
    int            my;
    int            i;
    int            j;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      half = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 16000) : $urandom_range(4, 600);
      jit  = half / 4;
      mx   = $urandom_range(half + jit, 65535 - half - jit);
      my   = $urandom_range(half + jit, 65535 - half - jit);
      px[0] = CB'(mx - half + $urandom_range(0, 2 * jit) - jit);
      py[0] = CB'(my - half + $urandom_range(0, 2 * jit) - jit);
      px[1] = CB'(mx + half + $urandom_range(0, 2 * jit) - jit);
      py[1] = CB'(my - half + $urandom_range(0, 2 * jit) - jit);
      px[2] = CB'(mx + half + $urandom_range(0, 2 * jit) - jit);
      py[2] = CB'(my + half + $urandom_range(0, 2 * jit) - jit);
      px[3] = CB'(mx - half + $urandom_range(0, 2 * jit) - jit);
      py[3] = CB'(my + half + $urandom_range(0, 2 * jit) - jit);
    end else if (r < 75) begin
      for (i = 0; i < 4; i++) begin
        px[i] = CB'($urandom);
        py[i] = CB'($urandom);
      end
    end else if (r < 88) begin
      for (i = 0; i < 4; i++) begin
        px[i] = CB'($urandom_range(0, 6));
        py[i] = CB'($urandom_range(0, 6));
      end
    end else begin
      for (i = 0; i < 4; i++) begin
        case ($urandom_range(0, 4))
          0: px[i] = '0;
          1: px[i] = '1;
          2: px[i] = 16'h8000;
          3: px[i] = 16'h7fff;
          default: px[i] = CB'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0: py[i] = '0;
          1: py[i] = '1;
          2: py[i] = 16'h8000;
          3: py[i] = 16'h7fff;
          default: py[i] = CB'($urandom);
        endcase
      end
    end
    // shuffle the corner order
    for (i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      tx = px[i]; px[i] = px[j]; px[j] = tx;
      ty = py[i]; py[i] = py[j]; py[j] = ty;
    end
    return pack_quad(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
  endfunction

  // Offer one word, hold it until taken, then idle for a random gap (none when steady)
  task automatic offer_quad(input logic [DW-1:0] quad, input bit steady);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= quad;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    quads_sent++;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom, $urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off while the
  // sender keeps offering so the pipeline fills and stalls its input
  initial begin : drain
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && quads_sent >= STALL_AT) begin
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        gap = ((cycle_count / 512) % 3 == 2) ? 0 : idle_len();
        if (gap == 0) begin
          m_tready <= 1'b1;
          @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Sender: directed corner cases, then random quads, then drain and verdict
  initial begin : feed
    int  n;
    bit  steady;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all corners at the origin, then all at the far corner
    offer_quad(pack_quad(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    offer_quad(pack_quad('1, '1, '1, '1, '1, '1, '1, '1), 1'b0);
    // all corners equal, nonzero
    offer_quad(pack_quad(16'h1234, 16'h5678, 16'h1234, 16'h5678,
                         16'h1234, 16'h5678, 16'h1234, 16'h5678), 1'b0);
    // square in counter-clockwise and in clockwise order
    offer_quad(pack_quad(100, 100, 200, 100, 200, 200, 100, 200), 1'b1);
    offer_quad(pack_quad(100, 200, 200, 200, 200, 100, 100, 100), 1'b1);
    // full-range square, two corner orders
    offer_quad(pack_quad(0, 0, '1, 0, '1, '1, 0, '1), 1'b0);
    offer_quad(pack_quad('1, '1, 0, 0, '1, 0, 0, '1), 1'b0);
    // one corner exactly on the centroid
    offer_quad(pack_quad(0, 0, 30, 0, 0, 30, 10, 10), 1'b0);
    offer_quad(pack_quad(10, 10, 0, 0, 30, 0, 0, 30), 1'b0);
    // diamond: corners straight left and at zero angle
    offer_quad(pack_quad(0, 50, 100, 50, 50, 0, 50, 100), 1'b1);
    offer_quad(pack_quad(100, 50, 50, 100, 0, 50, 50, 0), 1'b1);
    // collinear corners: equal angles keep input order
    offer_quad(pack_quad(0, 0, 10, 10, 20, 20, 30, 30), 1'b0);
    offer_quad(pack_quad(30, 30, 20, 20, 10, 10, 0, 0), 1'b0);
    offer_quad(pack_quad(0, 40, 10, 40, 20, 40, 30, 40), 1'b0);
    // duplicate corners
    offer_quad(pack_quad(5, 5, 5, 5, 9, 1, 1, 9), 1'b0);
    // tie on the distance to the origin
    offer_quad(pack_quad(10, 0, 0, 10, 20, 30, 30, 20), 1'b0);
    offer_quad(pack_quad(30, 20, 20, 30, 0, 10, 10, 0), 1'b0);
    // concave quad
    offer_quad(pack_quad(0, 0, 100, 0, 0, 100, 20, 20), 1'b0);
    // extremes mixed on each axis
    offer_quad(pack_quad(16'h8000, 0, '1, 16'h7fff, 16'h7fff, '1, 0, 16'h8000), 1'b0);

    n = 0;
    while (n < RANDOM_QUADS) begin
      steady = ((quads_sent / 128) % 3 == 1) ||
               (quads_sent >= STALL_AT - 5 && quads_sent < STALL_AT + STALL_CYCLES);
      offer_quad(random_quad(), steady);
      n++;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
sv/qcao_pkg.sv
sv/qcao_corner_lane.sv
sv/qcao_pair_lane.sv
sv/qcao_merge.sv
sv/quad_corner_angular_order_core.sv
test/quad_corner_order_checker.sv
test/quad_corner_angular_order_core_test.sv
